### design/blr_pkg.sv
// Shared types and constants for the line rasterizer.
// Depends on nothing; imported by the controller, datapath and top level.
`default_nettype none

package blr_pkg;

	// Coordinate, span and store widths fixed by the stream format
	localparam int CoordW = 12;
	localparam int DimW   = 11;
	localparam int FcntW  = 5;
	localparam int FrameW = 4;
	localparam int ColorW = 16;
	localparam int IndexW = 24;
	localparam int ErrW   = 14;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_FCOUNT = 2'd2,
		REG_DEPTH  = 2'd3
	} reg_idx_t;

	// Input item kind carried on s_tuser
	typedef enum logic {
		MODE_START = 1'b0,
		MODE_PULL  = 1'b1
	} mode_t;

	// Controller states
	typedef enum logic {
		ST_IDLE,
		ST_BASE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;   // latch endpoints, color, frame; start area multiply
		logic base;   // form frame base from the area product
		logic kill;   // drop the active line
		logic step;   // emit the current point and advance
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic active;
		logic frame_ok;
		logic out_valid;
	} sts_t;

	// One result point, x in the lowest bits
	typedef struct packed {
		logic        [ColorW-1:0] color;
		logic        [IndexW-1:0] index;
		logic signed [CoordW-1:0] y;
		logic signed [CoordW-1:0] x;
	} pix_t;

endpackage

`default_nettype wire

### design/blr_ctrl.sv
// Controller state machine for the line rasterizer.
// Depends on blr_pkg; drives commands into blr_dp and reads its status.
`default_nettype none

module blr_ctrl
	import blr_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output      logic   in_ready,
	input  wire logic   in_mode,
	input  wire logic   out_ready,
	input  wire sts_t   sts,
	output      cmd_t   cmd
);

	state_t state_q, state_d;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Decode accepted items into datapath commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = !sts.out_valid || out_ready;
				if (in_valid && in_ready) begin
					if (mode_t'(in_mode) == MODE_START) begin
						if (sts.frame_ok) begin
							cmd.load = 1'b1;
							state_d  = ST_BASE;
						end else begin
							cmd.kill = 1'b1;
						end
					end else if (sts.active) begin
						cmd.step = 1'b1;
					end
				end
			end
			ST_BASE: begin
				cmd.base = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### design/blr_dp.sv
// Datapath for the line rasterizer: config registers, Bresenham walk,
// frame base multiply, pixel index and output register. Depends on blr_pkg.
`default_nettype none

module blr_dp
	import blr_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_FRAMES = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_valid,
	input  wire logic [1:0]               cfg_index,
	input  wire logic [DimW-1:0]          cfg_data,
	input  wire logic signed [CoordW-1:0] start_x,
	input  wire logic signed [CoordW-1:0] start_y,
	input  wire logic signed [CoordW-1:0] end_x,
	input  wire logic signed [CoordW-1:0] end_y,
	input  wire logic [ColorW-1:0]        color,
	input  wire logic [FrameW-1:0]        frame,
	input  wire cmd_t                     cmd,
	output      sts_t                     sts,
	input  wire logic                     out_ready,
	output      logic                     out_valid,
	output      pix_t                     pix,
	output      logic                     visible,
	output      logic                     last
);

	localparam logic [DimW+1:0] MaxW13 = (DimW+2)'(MAX_WIDTH);
	localparam logic [DimW+1:0] MaxH13 = (DimW+2)'(MAX_HEIGHT);
	localparam logic [DimW-1:0] MaxW11 = DimW'(MAX_WIDTH);
	localparam logic [DimW-1:0] MaxH11 = DimW'(MAX_HEIGHT);
	localparam logic [8:0]      MaxF9  = 9'(MAX_FRAMES);

	// Configuration
	logic [DimW-1:0]  width_q, height_q;
	logic [FcntW-1:0] fcount_q;
	logic             depth16_q;

	// Line state
	logic                     active_q;
	logic signed [CoordW-1:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	logic [CoordW-1:0]        dx_q, dy_q;
	logic                     neg_x_q, neg_y_q;
	logic signed [ErrW-1:0]   err_q;
	logic [ColorW-1:0]        color_q;
	logic [FrameW-1:0]        frame_q;
	logic [2*DimW-1:0]        area_q;
	logic [IndexW-1:0]        base_q;

	// Output register
	logic out_valid_q;
	pix_t pix_q;
	logic vis_q, last_q;

	logic [DimW-1:0]          w_eff, h_eff;
	logic signed [CoordW:0]   dx_s, dy_s;
	logic [CoordW-1:0]        dx_abs, dy_abs;
	logic signed [ErrW-1:0]   err_init;
	logic signed [ErrW:0]     e2, neg_dy, err_nx;
	logic                     go_x, go_y, vis, fin;
	logic [2*DimW-1:0]        row_off;
	logic [IndexW-1:0]        idx;
	logic [FrameW+2*DimW-1:0] base_full;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= DimW'(64);
			height_q  <= DimW'(64);
			fcount_q  <= FcntW'(1);
			depth16_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_WIDTH:  width_q   <= cfg_data;
				REG_HEIGHT: height_q  <= cfg_data;
				REG_FCOUNT: fcount_q  <= cfg_data[FcntW-1:0];
				REG_DEPTH:  depth16_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Saturate the clip bounds
	assign w_eff = ({2'b00, width_q} > MaxW13) ? MaxW11 : width_q;
	assign h_eff = ({2'b00, height_q} > MaxH13) ? MaxH11 : height_q;

	assign sts.frame_ok  = (9'(frame) < 9'(fcount_q)) && (9'(frame) < MaxF9);
	assign sts.active    = active_q;
	assign sts.out_valid = out_valid_q;

	// Spans and initial error of a new line
	always_comb begin
		dx_s     = $signed({end_x[CoordW-1], end_x}) - $signed({start_x[CoordW-1], start_x});
		dy_s     = $signed({end_y[CoordW-1], end_y}) - $signed({start_y[CoordW-1], start_y});
		dx_abs   = dx_s[CoordW] ? CoordW'(-dx_s) : dx_s[CoordW-1:0];
		dy_abs   = dy_s[CoordW] ? CoordW'(-dy_s) : dy_s[CoordW-1:0];
		err_init = $signed({2'b00, dx_abs}) - $signed({2'b00, dy_abs});
	end

	// One Bresenham step from the current point
	always_comb begin
		e2     = $signed({err_q, 1'b0});
		neg_dy = -$signed({3'b000, dy_q});
		go_x   = e2 > neg_dy;
		go_y   = e2 < $signed({3'b000, dx_q});
		err_nx = $signed({err_q[ErrW-1], err_q})
			- (go_x ? $signed({3'b000, dy_q}) : $signed((ErrW+1)'(0)))
			+ (go_y ? $signed({3'b000, dx_q}) : $signed((ErrW+1)'(0)));
		fin    = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
	end

	// Clip test and store address of the current point
	always_comb begin
		vis     = !cur_x_q[CoordW-1] && !cur_y_q[CoordW-1]
			&& (cur_x_q[DimW-1:0] < w_eff) && (cur_y_q[DimW-1:0] < h_eff);
		row_off = cur_y_q[DimW-1:0] * w_eff;
		idx     = base_q + IndexW'(row_off) + IndexW'(cur_x_q[DimW-1:0]);
	end

	assign base_full = frame_q * area_q;

	// Load, advance and drop the line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			tgt_x_q  <= '0;
			tgt_y_q  <= '0;
			dx_q     <= '0;
			dy_q     <= '0;
			neg_x_q  <= 1'b0;
			neg_y_q  <= 1'b0;
			err_q    <= '0;
			color_q  <= '0;
			base_q   <= '0;
		end else begin
			if (cmd.load) begin
				active_q <= 1'b1;
				cur_x_q  <= start_x;
				cur_y_q  <= start_y;
				tgt_x_q  <= end_x;
				tgt_y_q  <= end_y;
				dx_q     <= dx_abs;
				dy_q     <= dy_abs;
				neg_x_q  <= dx_s[CoordW];
				neg_y_q  <= dy_s[CoordW];
				err_q    <= err_init;
				color_q  <= color;
			end else if (cmd.kill) begin
				active_q <= 1'b0;
			end else if (cmd.step) begin
				if (fin) begin
					active_q <= 1'b0;
				end else begin
					err_q <= err_nx[ErrW-1:0];
					if (go_x) begin
						cur_x_q <= neg_x_q ? cur_x_q - CoordW'(1) : cur_x_q + CoordW'(1);
					end
					if (go_y) begin
						cur_y_q <= neg_y_q ? cur_y_q - CoordW'(1) : cur_y_q + CoordW'(1);
					end
				end
			end
			if (cmd.base) begin
				base_q <= base_full[IndexW-1:0];
			end
		end
	end

	// Frame area product, taken at load and used in the cycle after
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			frame_q <= frame;
			area_q  <= w_eff * h_eff;
		end
	end

	// Hold the result until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			pix_q.x     <= cur_x_q;
			pix_q.y     <= cur_y_q;
			pix_q.index <= vis ? idx : '0;
			pix_q.color <= depth16_q ? color_q : {8'h00, color_q[7:0]};
			vis_q       <= vis;
			last_q      <= fin;
		end
	end

	assign out_valid = out_valid_q;
	assign pix       = pix_q;
	assign visible   = vis_q;
	assign last      = last_q;

endmodule

`default_nettype wire

### design/bresenham_line_rasterizer.sv
// Pull item: its point appears on the master side in the cycle after the transfer;
// pulls are taken every cycle while results drain. Accepted start item: the slave
// side stalls in ST_BASE while the frame base multiply (frame*width*height)
// settles; a rejected start does not stall. Reset (arst_n low, asynchronous) drops
// any line, clears the output, and sets width 64, height 64, one frame, 16-bit pixels.
// Top level: joins blr_ctrl and blr_dp; depends on blr_pkg.
`default_nettype none

module bresenham_line_rasterizer
	import blr_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_FRAMES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write channel
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [10:0] cfg_data,
	// Slave side
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [71:0] s_tdata,  // start_x, start_y, end_x, end_y, color, frame, zero pad
	input  wire logic        s_tuser,  // mode
	// Master side
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [63:0] m_tdata,  // pixel_x, pixel_y, pixel_index, pixel_color
	output      logic        m_tuser,  // visible
	output      logic        m_tlast
);

	cmd_t cmd;
	sts_t sts;
	pix_t pix;

	assign cfg_ready = 1'b1;

	blr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (s_tuser),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	blr_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_FRAMES (MAX_FRAMES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.start_x   (s_tdata[11:0]),
		.start_y   (s_tdata[23:12]),
		.end_x     (s_tdata[35:24]),
		.end_y     (s_tdata[47:36]),
		.color     (s_tdata[63:48]),
		.frame     (s_tdata[67:64]),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.pix       (pix),
		.visible   (m_tuser),
		.last      (m_tlast)
	);

	assign m_tdata = pix;

endmodule

`default_nettype wire

### design/blr_checker.sv
// Port-level checks for the line rasterizer, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module blr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata,
	input wire logic        m_tuser
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A waiting result holds off the slave side
	a_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while a result waits");

	// A new result follows only a pull transfer
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser))
		else $error("result without a pull");

	// Clipped points carry a zero index
	a_clip_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[47:24] == 24'd0)
		else $error("nonzero index on clipped point");

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

### sim/bresenham_line_rasterizer_tb.sv
// Self-checking testbench for the Bresenham line rasterizer stream block.
// Depends on blr_pkg and bresenham_line_rasterizer; needs no files or arguments.
`timescale 1ns / 1ps

module bresenham_line_rasterizer_tb;
	import blr_pkg::*;

	localparam int MaxW = 1024;
	localparam int MaxH = 1024;
	localparam int MaxF = 16;

	// One slave-side item, as the stimulus sees it
	typedef struct packed {
		mode_t       mode;
		logic [11:0] sx;
		logic [11:0] sy;
		logic [11:0] ex;
		logic [11:0] ey;
		logic [15:0] color;
		logic [3:0]  frame;
	} line_cmd_t;

	// One master-side point with its flags
	typedef struct packed {
		logic last;
		logic vis;
		pix_t pix;
	} point_t;

	// Directed stimulus row; want is used only when typed is set
	typedef struct packed {
		line_cmd_t cmd;
		logic      typed;
		point_t    want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_WIDTH;
	logic [10:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;   // start_x, start_y, end_x, end_y, color, frame, zero pad
	logic        s_tuser = 1'b0; // mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;        // pixel_x, pixel_y, pixel_index, pixel_color
	logic        m_tuser;        // visible
	logic        m_tlast;

	// Register copies seen by the line walker
	int        cfg_w = 64;
	int        cfg_h = 64;
	int        cfg_fc = 1;
	bit        cfg_d16 = 1'b1;

	// Line walker state
	bit        walk_on = 1'b0;
	int        cur_x, cur_y, dst_x, dst_y, span_x, span_y, err_acc;
	bit        neg_x, neg_y;
	logic [15:0] ink;
	int        frame_base;

	point_t    pending_pts[$];
	plan_row_t plan[$];

	int        fault_cnt = 0;
	int        n_items = 0;
	int        n_points = 0;
	int        n_vis = 0;
	int        n_last = 0;
	int        n_settings = 1;
	bit        calm = 1'b0;
	bit        hold_req = 1'b0;

	bresenham_line_rasterizer #(
		.MAX_WIDTH (MaxW),
		.MAX_HEIGHT(MaxH),
		.MAX_FRAMES(MaxF)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Hard stop in case the block hangs
	initial begin
		#3_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic line_cmd_t mk_cmd(input mode_t m, input int sx, input int sy,
			input int ex, input int ey, input int col, input int fr);
		line_cmd_t c;
		c.mode  = m;
		c.sx    = 12'(sx);
		c.sy    = 12'(sy);
		c.ex    = 12'(ex);
		c.ey    = 12'(ey);
		c.color = 16'(col);
		c.frame = 4'(fr);
		return c;
	endfunction

	function automatic line_cmd_t pull_cmd();
		return mk_cmd(MODE_PULL, 0, 0, 0, 0, 0, 0);
	endfunction

	function automatic point_t mk_pt(input int x, input int y, input int idx, input int col,
			input bit vis, input bit last);
		point_t p;
		p.pix.x     = 12'(x);
		p.pix.y     = 12'(y);
		p.pix.index = 24'(idx);
		p.pix.color = 16'(col);
		p.vis       = vis;
		p.last      = last;
		return p;
	endfunction

	function automatic logic [11:0] to_coord(input int v);
		if (v > 2047)
			v = 2047;
		else if (v < -2048)
			v = -2048;
		return 12'(v);
	endfunction

	// Walk the line one item at a time; returns 1 when the item yields a point
	function automatic bit next_point(input line_cmd_t c, output point_t pt);
		int w, h, lim, idx, e2;
		bit vis, fin;
		pt = '0;
		w = (cfg_w > MaxW) ? MaxW : cfg_w;
		h = (cfg_h > MaxH) ? MaxH : cfg_h;
		if (c.mode == MODE_START) begin
			lim = (cfg_fc > MaxF) ? MaxF : cfg_fc;
			if (int'(c.frame) >= lim) begin
				walk_on = 1'b0;
				return 1'b0;
			end
			cur_x   = $signed(c.sx);
			cur_y   = $signed(c.sy);
			dst_x   = $signed(c.ex);
			dst_y   = $signed(c.ey);
			span_x  = (dst_x >= cur_x) ? dst_x - cur_x : cur_x - dst_x;
			span_y  = (dst_y >= cur_y) ? dst_y - cur_y : cur_y - dst_y;
			neg_x   = dst_x < cur_x;
			neg_y   = dst_y < cur_y;
			err_acc = span_x - span_y;
			ink     = c.color;
			frame_base = (int'(c.frame) * w * h) & 24'hFF_FFFF;
			walk_on = 1'b1;
			return 1'b0;
		end
		if (!walk_on)
			return 1'b0;
		vis = cur_x >= 0 && cur_y >= 0 && cur_x < w && cur_y < h;
		fin = cur_x == dst_x && cur_y == dst_y;
		idx = vis ? frame_base + cur_y * w + cur_x : 0;
		pt.pix.x     = 12'(cur_x);
		pt.pix.y     = 12'(cur_y);
		pt.pix.index = 24'(idx);
		pt.pix.color = cfg_d16 ? ink : {8'h00, ink[7:0]};
		pt.vis       = vis;
		pt.last      = fin;
		// Advance the error term, or drop the line on its last point
		if (fin) begin
			walk_on = 1'b0;
		end else begin
			e2 = 2 * err_acc;
			if (e2 > -span_y) begin
				err_acc -= span_y;
				cur_x += neg_x ? -1 : 1;
			end
			if (e2 < span_x) begin
				err_acc += span_x;
				cur_y += neg_y ? -1 : 1;
			end
		end
		return 1'b1;
	endfunction

	task automatic add_row(input line_cmd_t c, input bit typed, input point_t w);
		plan_row_t r;
		r.cmd   = c;
		r.typed = typed;
		r.want  = w;
		plan.push_back(r);
	endtask

	// Offer one item, wait for its transfer, then record what it should produce
	task automatic push_item(input line_cmd_t c, input bit typed, input point_t want);
		point_t p;
		bit has;
		while (!calm && $urandom_range(99) < 15) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c.mode;
		s_tdata  <= {4'h0, c.frame, c.color, c.ey, c.ex, c.sy, c.sx};
		do @(posedge clk); while (!s_tready);
		has = next_point(c, p);
		if (has)
			pending_pts.push_back(typed ? want : p);
		if (c.mode == MODE_START || has)
			n_items++;
	endtask

	task automatic send(input line_cmd_t c);
		push_item(c, 1'b0, point_t'(0));
	endtask

	// Drop valid, let every expected point drain, then cover the start latency
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_pts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(input int w, input int h, input int fc, input int d);
		logic [10:0] vals[4];
		vals[0] = 11'(w);
		vals[1] = 11'(h);
		vals[2] = 11'(fc);
		vals[3] = 11'(d);
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= 2'(i);
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			case (reg_idx_t'(i))
				REG_WIDTH: begin
					cfg_w = vals[i];
				end
				REG_HEIGHT: begin
					cfg_h = vals[i];
				end
				REG_FCOUNT: begin
					cfg_fc = vals[i][4:0];
				end
				REG_DEPTH: begin
					cfg_d16 = vals[i][0];
				end
			endcase
		end
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	task automatic draw_line(input int x0, input int y0, input int x1, input int y1,
			input int fr, input int pulls);
		send(mk_cmd(MODE_START, x0, y0, x1, y1, $urandom_range(16'hFFFF), fr));
		repeat (pulls) send(pull_cmd());
	endtask

	// One random sequence: mostly whole lines, some cut short, bad frames and noise
	task automatic random_seq();
		int r, lim, ew, eh, x0, y0, x1, y1, n, reach;
		r   = $urandom_range(99);
		lim = (cfg_fc > MaxF) ? MaxF : cfg_fc;
		ew  = (cfg_w > MaxW) ? MaxW : cfg_w;
		eh  = (cfg_h > MaxH) ? MaxH : cfg_h;
		if (r < 10) begin
			send(mk_cmd(mode_t'($urandom_range(1)), $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom));
		end else if ((r < 20 && lim < MaxF) || lim == 0) begin
			draw_line($urandom_range(ew), $urandom_range(eh), $urandom_range(ew),
				$urandom_range(eh), $urandom_range(15, lim), $urandom_range(2));
		end else begin
			if (r < 25) begin
				x0 = $signed(12'($urandom));
				y0 = $signed(12'($urandom));
				x1 = $signed(12'($urandom));
				y1 = $signed(12'($urandom));
			end else begin
				reach = (r < 32) ? 120 : 12;
				x0 = int'($urandom_range(ew + 16)) - 8;
				y0 = int'($urandom_range(eh + 16)) - 8;
				x1 = x0 + int'($urandom_range(2 * reach)) - reach;
				y1 = y0 + int'($urandom_range(2 * reach)) - reach;
			end
			x0 = $signed(to_coord(x0));
			y0 = $signed(to_coord(y0));
			x1 = $signed(to_coord(x1));
			y1 = $signed(to_coord(y1));
			n = (x1 > x0 ? x1 - x0 : x0 - x1);
			if ((y1 > y0 ? y1 - y0 : y0 - y1) > n)
				n = (y1 > y0 ? y1 - y0 : y0 - y1);
			n = n + 1;
			r = $urandom_range(99);
			if (r < 12)
				n = $urandom_range(n - 1);
			else if (r < 24)
				n = n + $urandom_range(1, 3);
			if (n > 80)
				n = 80;
			draw_line(x0, y0, x1, y1, $urandom_range(lim - 1), n);
		end
	endtask

	// Receiver pacing: random stalls, a calm stretch, and one long hold-off
	initial begin : rx_pace
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if (calm) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 15);
			end
		end
	end

	// Compare each transferred point with the oldest expected one
	always @(posedge clk) begin : point_check
		point_t want;
		pix_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_pts.size() == 0) begin
				$error("point with nothing expected: x %0d y %0d",
					$signed(got.x), $signed(got.y));
				fault_cnt++;
			end else begin
				want = pending_pts.pop_front();
				n_points++;
				if (want.vis)
					n_vis++;
				if (want.last)
					n_last++;
				if (got.x !== want.pix.x) begin
					$error("pixel_x: expected %0d, got %0d",
						$signed(want.pix.x), $signed(got.x));
					fault_cnt++;
				end
				if (got.y !== want.pix.y) begin
					$error("pixel_y: expected %0d, got %0d",
						$signed(want.pix.y), $signed(got.y));
					fault_cnt++;
				end
				if (got.index !== want.pix.index) begin
					$error("pixel_index: expected %0d, got %0d", want.pix.index, got.index);
					fault_cnt++;
				end
				if (got.color !== want.pix.color) begin
					$error("pixel_color: expected %h, got %h", want.pix.color, got.color);
					fault_cnt++;
				end
				if (m_tuser !== want.vis) begin
					$error("visible: expected %b, got %b", want.vis, m_tuser);
					fault_cnt++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %b, got %b", want.last, m_tlast);
					fault_cnt++;
				end
			end
		end
	end

	// Main stimulus
	initial begin : stimulus
		int ph_w[7]     = '{48, 1, 2047, 1024, 0, 20, 0};
		int ph_h[7]     = '{40, 1, 2047, 1024, 37, 2047, 0};
		int ph_fc[7]    = '{16, 2, 31, 16, 5, 0, 0};
		int ph_d[7]     = '{0, 1, 0, 1, 0, 1, 0};
		int ph_items[7] = '{170, 170, 170, 170, 170, 40, 170};
		int goal;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows under the reset settings: 64x64, one frame, 16-bit pixels
		add_row(pull_cmd(), 1'b0, '0);
		add_row(mk_cmd(MODE_START, 0, 0, 0, 0, 16'hFFFF, 0), 1'b0, '0);
		add_row(pull_cmd(), 1'b1, mk_pt(0, 0, 0, 16'hFFFF, 1'b1, 1'b1));
		add_row(pull_cmd(), 1'b0, '0);
		add_row(mk_cmd(MODE_START, 1, 1, 2, 2, 16'h5A5A, 15), 1'b0, '0);
		add_row(pull_cmd(), 1'b0, '0);
		add_row(mk_cmd(MODE_START, 63, 63, 64, 64, 16'h1234, 0), 1'b0, '0);
		add_row(pull_cmd(), 1'b1, mk_pt(63, 63, 4095, 16'h1234, 1'b1, 1'b0));
		add_row(pull_cmd(), 1'b1, mk_pt(64, 64, 0, 16'h1234, 1'b0, 1'b1));
		add_row(mk_cmd(MODE_START, -2048, 2047, 2047, -2048, 16'hA5C3, 0), 1'b0, '0);
		add_row(pull_cmd(), 1'b1, mk_pt(-2048, 2047, 0, 16'hA5C3, 1'b0, 1'b0));
		add_row(pull_cmd(), 1'b0, '0);
		// Horizontal line abandons the diagonal in progress
		add_row(mk_cmd(MODE_START, -2, 5, 2, 5, 16'h00FF, 0), 1'b0, '0);
		repeat (5) add_row(pull_cmd(), 1'b0, '0);
		// Vertical line walking upward
		add_row(mk_cmd(MODE_START, 5, 2, 5, -2, 16'h8001, 0), 1'b0, '0);
		repeat (5) add_row(pull_cmd(), 1'b0, '0);
		foreach (plan[i])
			push_item(plan[i].cmd, plan[i].typed, plan[i].want);

		// Random phases, each under its own register setting
		goal = n_items;
		for (int ph = 0; ph < 7; ph++) begin
			settle();
			if (ph == 6)
				set_regs($urandom_range(1, 200), $urandom_range(1, 200),
					$urandom_range(1, 16), $urandom_range(1));
			else
				set_regs(ph_w[ph], ph_h[ph], ph_fc[ph], ph_d[ph]);
			calm = (ph == 3);
			// Pull more points from any line left open across the register change
			repeat (3) send(pull_cmd());
			if (ph == 0) begin
				hold_req = 1'b1;
				draw_line(0, 0, 150, 37, 3, 151);
			end
			goal += ph_items[ph];
			while (n_items < goal)
				random_seq();
			// Leave a line half drawn for the next setting
			draw_line(2, 3, 11, 7, 0, 2);
		end
		calm = 1'b0;
		settle();

		$display("Ran %0d line items over %0d register settings.", n_items, n_settings);
		$display("Checked %0d points: %0d inside the frame, %0d line ends.",
			n_points, n_vis, n_last);
		if (fault_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
